// ===== src/tffdp_pkg.sv =====
// Shared constants, codes, types and helper functions for the TX FIFO pacer.
// Used by tffdp_div and tx_fifo_fill_drain_pacer; no dependencies.
package tffdp_pkg;

    // Sizing of the FIFO and the sync spacing
    localparam int unsigned FIFO_DEPTH_BYTES    = 20480;
    localparam int unsigned READY_LEVEL_BYTES   = 2048;
    localparam int unsigned SYNC_INTERVAL_BYTES = 8192;
    localparam int unsigned FILL_MARGIN_BYTES   = 1024;
    localparam int unsigned STOP_WAIT_TICKS     = 10;

    localparam int unsigned LEN_W     = 12;
    localparam int unsigned LEVEL_W   = 15;
    localparam int unsigned CNT_W     = 16;
    localparam int unsigned RETRY_W   = 8;
    localparam int unsigned CMD_W     = 3;
    localparam int unsigned DIVISOR_W = 11;
    localparam int unsigned DIV_STEPS = RETRY_W;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

    localparam logic [LEVEL_W-1:0] FILL_THRESHOLD =
        LEVEL_W'(FIFO_DEPTH_BYTES - FILL_MARGIN_BYTES);
    localparam logic [LEVEL_W-1:0] READY_LEVEL = LEVEL_W'(READY_LEVEL_BYTES);
    localparam logic [CNT_W-1:0]   SYNC_RELOAD = CNT_W'(SYNC_INTERVAL_BYTES);
    localparam logic [3:0]         STOP_TICKS  = 4'(STOP_WAIT_TICKS);

    // Event codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_SEND  = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // Command codes
    typedef logic [CMD_W-1:0] cmd_t;
    localparam cmd_t CMD_NONE        = 3'd0;
    localparam cmd_t CMD_SYNC_MODE   = 3'd1;
    localparam cmd_t CMD_SEND_SYNC   = 3'd2;
    localparam cmd_t CMD_TRANSMIT    = 3'd3;
    localparam cmd_t CMD_DATA_MODE   = 3'd4;
    localparam cmd_t CMD_CONFIG_MODE = 3'd5;

    // Phase codes
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_FIRST  = 3'd1;
    localparam logic [2:0] PH_FILL   = 3'd2;
    localparam logic [2:0] PH_DRAIN  = 3'd3;
    localparam logic [2:0] PH_SDRAIN = 3'd4;
    localparam logic [2:0] PH_SWAIT  = 3'd5;

    // Rate codes
    localparam logic [1:0] RATE_FULL    = 2'd0;
    localparam logic [1:0] RATE_HALF    = 2'd1;
    localparam logic [1:0] RATE_QUARTER = 2'd2;
    localparam logic [1:0] RATE_INVALID = 2'd3;

    typedef struct packed {
        logic                 start;
        logic [LEVEL_W-1:0]   dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [RETRY_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [2:0] rate_divisor_for(input logic [1:0] code);
        logic [2:0] d;
        unique case (code)
            RATE_FULL:    d = 3'd1;
            RATE_HALF:    d = 3'd2;
            RATE_QUARTER: d = 3'd4;
            RATE_INVALID: d = 3'd5;
            default:      d = 3'd1;
        endcase
        return d;
    endfunction

    // limit = (level / (512/div)) / 2 folds into level / (1024/div), 102*2 for div 5
    function automatic logic [DIVISOR_W-1:0] drain_divisor(input logic [2:0] rdiv);
        logic [DIVISOR_W-1:0] d;
        case (rdiv)
            3'd2:    d = 11'd512;
            3'd4:    d = 11'd256;
            3'd5:    d = 11'd204;
            default: d = 11'd1024;
        endcase
        return d;
    endfunction

endpackage

// ===== src/tffdp_div.sv =====
// Iterative restoring divider: one quotient bit per cycle, shared compare/subtract.
// Depends on tffdp_pkg.
module tffdp_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tffdp_pkg::div_req_t  req,
    output tffdp_pkg::div_rsp_t  rsp
);

    localparam int unsigned WIDE_W = tffdp_pkg::DIVISOR_W + tffdp_pkg::DIV_STEPS - 1;

    logic [tffdp_pkg::LEVEL_W-1:0]   rem_reg, rem_next;
    logic [tffdp_pkg::RETRY_W-1:0]   quo_reg, quo_next;
    logic [tffdp_pkg::DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [tffdp_pkg::STEP_W-1:0]    step_reg, step_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;

    logic [WIDE_W-1:0] shifted;
    logic [WIDE_W-1:0] rem_wide;
    logic              fits;

    always_comb begin
        shifted  = WIDE_W'(dvs_reg) << step_reg;
        rem_wide = WIDE_W'(rem_reg);
        fits     = rem_wide >= shifted;

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start) begin
            rem_next  = req.dividend;
            dvs_next  = req.divisor;
            quo_next  = '0;
            step_next = tffdp_pkg::STEP_W'(tffdp_pkg::DIV_STEPS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = rem_reg - shifted[tffdp_pkg::LEVEL_W-1:0];
            end
            quo_next[step_reg] = fits;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== src/tx_fifo_fill_drain_pacer.sv =====
// Top level of the TX FIFO fill/drain pacer: event sequencer, APB register, result queue.
// Depends on tffdp_pkg and tffdp_div.
//
// One event word is taken at a time; s_ready is high only while the block waits for
// the next word. An event is captured, then evaluated, then its result words (1 to 3)
// go out one per cycle while the sink keeps m_ready high. An event that starts a
// drain wait (a send reaching the fill threshold, or a stop) also runs the retry-limit
// division in the divider, 8 steps, before its result words go out. rate_code is
// written through the APB port at addresses 0 to 3 (paddr[2] low) and takes effect
// at the next start event.
module tx_fifo_fill_drain_pacer (
    input  logic        aclk,
    input  logic        aresetn,
    // event channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [11:0] s_frame_length,
    input  logic        s_tx_ready,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_command,
    output logic [11:0] m_tx_length,
    output logic        m_busy_res,
    output logic [15:0] m_too_slow_count,
    output logic [15:0] m_too_fast_count,
    output logic        m_last,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam logic ADDR_RATE_CODE = 1'b0;

    localparam logic [tffdp_pkg::CNT_W-1:0] CNT_MAX = '1;

    logic [1:0]                      state_reg, state_next;
    logic [1:0]                      op_reg, op_next;
    logic [tffdp_pkg::LEN_W-1:0]     len_reg, len_next;
    logic                            rdy_reg, rdy_next;
    logic [1:0]                      rate_code_reg, rate_code_next;
    logic [2:0]                      phase_reg, phase_next;
    logic [tffdp_pkg::LEVEL_W-1:0]   level_reg, level_next;
    logic [tffdp_pkg::CNT_W-1:0]     sync_reg, sync_next;
    logic [2:0]                      rate_div_reg, rate_div_next;
    logic [tffdp_pkg::RETRY_W-1:0]   retry_cnt_reg, retry_cnt_next;
    logic [tffdp_pkg::RETRY_W-1:0]   retry_lim_reg, retry_lim_next;
    logic [3:0]                      stop_reg, stop_next;
    logic [tffdp_pkg::CNT_W-1:0]     slow_reg, slow_next;
    logic [tffdp_pkg::CNT_W-1:0]     fast_reg, fast_next;
    tffdp_pkg::cmd_t                 q_cmd_reg [3];
    tffdp_pkg::cmd_t                 q_cmd_next [3];
    logic [1:0]                      q_num_reg, q_num_next;
    logic [1:0]                      q_idx_reg, q_idx_next;

    tffdp_pkg::div_req_t div_req;
    tffdp_pkg::div_rsp_t div_rsp;

    logic busy_phase;
    logic cfg_wr;

    tffdp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign busy_phase = (phase_reg == tffdp_pkg::PH_DRAIN) ||
                        (phase_reg == tffdp_pkg::PH_SDRAIN) ||
                        (phase_reg == tffdp_pkg::PH_SWAIT);

    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign rate_code_next = (cfg_wr && paddr[2] == ADDR_RATE_CODE) ? pwdata[1:0]
                                                                  : rate_code_reg;
    assign prdata = (paddr[2] == ADDR_RATE_CODE) ? {30'd0, rate_code_reg} : 32'd0;

    always_comb begin
        logic [1:0]                    n;
        logic                          drain;
        logic [tffdp_pkg::CNT_W-1:0]   sync_cur;
        logic [tffdp_pkg::LEVEL_W:0]   lvl_sum;

        n        = '0;
        drain    = 1'b0;
        sync_cur = sync_reg;
        lvl_sum  = '0;

        state_next     = state_reg;
        op_next        = op_reg;
        len_next       = len_reg;
        rdy_next       = rdy_reg;
        phase_next     = phase_reg;
        level_next     = level_reg;
        sync_next      = sync_reg;
        rate_div_next  = rate_div_reg;
        retry_cnt_next = retry_cnt_reg;
        retry_lim_next = retry_lim_reg;
        stop_next      = stop_reg;
        slow_next      = slow_reg;
        fast_next      = fast_reg;
        q_cmd_next     = q_cmd_reg;
        q_num_next     = q_num_reg;
        q_idx_next     = q_idx_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_op;
                    len_next   = s_frame_length;
                    rdy_next   = s_tx_ready;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (op_reg == tffdp_pkg::OP_TICK) begin
                    if (phase_reg == tffdp_pkg::PH_DRAIN ||
                        phase_reg == tffdp_pkg::PH_SDRAIN) begin
                        if (rdy_reg || retry_cnt_reg >= retry_lim_reg) begin
                            if (retry_cnt_reg == '0) begin
                                if (slow_reg != CNT_MAX) begin
                                    slow_next = slow_reg + 1'b1;
                                end
                            end else if (retry_cnt_reg >= retry_lim_reg) begin
                                if (fast_reg != CNT_MAX) begin
                                    fast_next = fast_reg + 1'b1;
                                end
                            end
                            level_next = tffdp_pkg::READY_LEVEL;
                            if (phase_reg == tffdp_pkg::PH_DRAIN) begin
                                phase_next = tffdp_pkg::PH_FILL;
                            end else begin
                                phase_next = tffdp_pkg::PH_SWAIT;
                                stop_next  = tffdp_pkg::STOP_TICKS;
                            end
                        end else begin
                            retry_cnt_next = retry_cnt_reg + 1'b1;
                        end
                    end else if (phase_reg == tffdp_pkg::PH_SWAIT) begin
                        if (stop_reg > 4'd1) begin
                            stop_next = stop_reg - 1'b1;
                        end else begin
                            stop_next     = '0;
                            phase_next    = tffdp_pkg::PH_IDLE;
                            q_cmd_next[n] = tffdp_pkg::CMD_CONFIG_MODE;
                            n             = n + 1'b1;
                        end
                    end
                end else if (!busy_phase) begin
                    unique case (op_reg)
                        tffdp_pkg::OP_START: begin
                            rate_div_next = tffdp_pkg::rate_divisor_for(rate_code_reg);
                            phase_next    = tffdp_pkg::PH_FIRST;
                            q_cmd_next[n] = tffdp_pkg::CMD_SYNC_MODE;
                            n             = n + 1'b1;
                        end
                        tffdp_pkg::OP_SEND: begin
                            if (sync_reg == '0) begin
                                q_cmd_next[n] = tffdp_pkg::CMD_SEND_SYNC;
                                n             = n + 1'b1;
                                sync_cur      = tffdp_pkg::SYNC_RELOAD;
                            end
                            q_cmd_next[n] = tffdp_pkg::CMD_TRANSMIT;
                            n             = n + 1'b1;
                            // countdown stops at zero
                            sync_next = (sync_cur > tffdp_pkg::CNT_W'(len_reg))
                                      ? sync_cur - tffdp_pkg::CNT_W'(len_reg) : '0;
                            lvl_sum = {1'b0, level_reg} +
                                      (tffdp_pkg::LEVEL_W + 1)'(len_reg);
                            level_next = lvl_sum[tffdp_pkg::LEVEL_W] ? '1
                                       : lvl_sum[tffdp_pkg::LEVEL_W-1:0];
                            if (level_next >= tffdp_pkg::FILL_THRESHOLD) begin
                                if (phase_reg == tffdp_pkg::PH_FIRST) begin
                                    q_cmd_next[n] = tffdp_pkg::CMD_DATA_MODE;
                                    n             = n + 1'b1;
                                end
                                drain      = 1'b1;
                                phase_next = tffdp_pkg::PH_DRAIN;
                            end
                        end
                        tffdp_pkg::OP_STOP: begin
                            drain      = 1'b1;
                            phase_next = tffdp_pkg::PH_SDRAIN;
                        end
                        default: begin
                        end
                    endcase
                end
                if (n == '0) begin
                    q_cmd_next[0] = tffdp_pkg::CMD_NONE;
                    n             = 2'd1;
                end
                q_num_next = n;
                q_idx_next = '0;
                if (drain) begin
                    retry_cnt_next = '0;
                    state_next     = S_DIV;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    retry_lim_next = div_rsp.quotient;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (m_ready) begin
                    if (q_idx_reg == q_num_reg - 1'b1) begin
                        state_next = S_IDLE;
                    end else begin
                        q_idx_next = q_idx_reg + 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase

        div_req.start    = drain;
        div_req.dividend = level_next;
        div_req.divisor  = tffdp_pkg::drain_divisor(rate_div_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            rate_code_reg <= tffdp_pkg::RATE_FULL;
            phase_reg     <= tffdp_pkg::PH_IDLE;
            level_reg     <= '0;
            sync_reg      <= '0;
            rate_div_reg  <= 3'd1;
            retry_cnt_reg <= '0;
            retry_lim_reg <= '0;
            stop_reg      <= '0;
            slow_reg      <= '0;
            fast_reg      <= '0;
            q_num_reg     <= '0;
            q_idx_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            rate_code_reg <= rate_code_next;
            phase_reg     <= phase_next;
            level_reg     <= level_next;
            sync_reg      <= sync_next;
            rate_div_reg  <= rate_div_next;
            retry_cnt_reg <= retry_cnt_next;
            retry_lim_reg <= retry_lim_next;
            stop_reg      <= stop_next;
            slow_reg      <= slow_next;
            fast_reg      <= fast_next;
            q_num_reg     <= q_num_next;
            q_idx_reg     <= q_idx_next;
        end
        op_reg    <= op_next;
        len_reg   <= len_next;
        rdy_reg   <= rdy_next;
        q_cmd_reg <= q_cmd_next;
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = (state_reg == S_EMIT);
    assign m_command        = q_cmd_reg[q_idx_reg];
    assign m_tx_length      = (q_cmd_reg[q_idx_reg] == tffdp_pkg::CMD_TRANSMIT) ? len_reg : '0;
    assign m_busy_res       = busy_phase;
    assign m_too_slow_count = slow_reg;
    assign m_too_fast_count = fast_reg;
    assign m_last           = (q_idx_reg == q_num_reg - 1'b1);

endmodule
